// ----- rtl/ult_pkg.sv -----
package ult_pkg;

	localparam int OP_W   = 3;
	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;

	// request codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT     = 3'd0,
		OP_DELETE     = 3'd1,
		OP_RETRIEVE   = 3'd2,
		OP_RESET_ITER = 3'd3,
		OP_GET_NEXT   = 3'd4,
		OP_MAKE_EMPTY = 3'd5
	} op_t;

	// microprogram addresses
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_WR,
		ST_DEL_SCAN,
		ST_DEL_CHK,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_RET_SCAN,
		ST_RET_CHK,
		ST_RET_OUT,
		ST_RIT,
		ST_GN,
		ST_GN_RD,
		ST_GN_OUT,
		ST_MKE,
		ST_ERR,
		ST_DONE
	} upc_t;

	// sequencing modes
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_BRANCH,
		SEQ_WAIT,
		SEQ_DISPATCH
	} seq_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_TRUE,
		C_FULL,
		C_MISS,
		C_ITER_END,
		C_SCAN_DONE,
		C_OUT_FREE
	} cond_t;

	// table address sources
	typedef enum logic [1:0] {
		A_COUNT,
		A_LAST,
		A_ITER,
		A_LOC
	} addr_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	typedef enum logic [1:0] {
		IT_HOLD,
		IT_CLR,
		IT_INC
	} iter_op_t;

	// one control word
	typedef struct packed {
		seq_t     seq;
		cond_t    cond;
		upc_t     target;
		logic     scan;
		logic     rd;
		logic     wr;
		addr_t    addr;
		logic     wd_rdata;
		cnt_op_t  cnt_op;
		iter_op_t iter_op;
		logic     load_kd;
		logic     set_err;
		logic     emit;
	} uword_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic full;
		logic miss;
		logic iter_end;
		logic scan_done;
		logic out_free;
	} status_t;

	// control store
	function automatic uword_t ucode(upc_t s);
		uword_t w;
		w        = '0;
		w.seq    = SEQ_NEXT;
		w.cond   = C_TRUE;
		w.target = ST_IDLE;
		case (s)
			ST_IDLE: begin
				w.seq = SEQ_DISPATCH;
			end
			ST_INS: begin
				w.seq    = SEQ_BRANCH;
				w.cond   = C_FULL;
				w.target = ST_ERR;
			end
			ST_INS_WR: begin
				w.wr     = 1'b1;
				w.addr   = A_COUNT;
				w.cnt_op = CNT_INC;
				w.seq    = SEQ_BRANCH;
				w.target = ST_DONE;
			end
			ST_DEL_SCAN: begin
				w.scan   = 1'b1;
				w.seq    = SEQ_WAIT;
				w.cond   = C_SCAN_DONE;
				w.target = ST_DEL_CHK;
			end
			ST_DEL_CHK: begin
				w.seq    = SEQ_BRANCH;
				w.cond   = C_MISS;
				w.target = ST_ERR;
			end
			ST_DEL_RD: begin
				w.rd   = 1'b1;
				w.addr = A_LAST;
			end
			ST_DEL_WR: begin
				w.wr       = 1'b1;
				w.addr     = A_LOC;
				w.wd_rdata = 1'b1;
				w.cnt_op   = CNT_DEC;
				w.seq      = SEQ_BRANCH;
				w.target   = ST_DONE;
			end
			ST_RET_SCAN: begin
				w.scan   = 1'b1;
				w.seq    = SEQ_WAIT;
				w.cond   = C_SCAN_DONE;
				w.target = ST_RET_CHK;
			end
			ST_RET_CHK: begin
				w.seq    = SEQ_BRANCH;
				w.cond   = C_MISS;
				w.target = ST_DONE;
			end
			ST_RET_OUT: begin
				w.load_kd = 1'b1;
				w.seq     = SEQ_BRANCH;
				w.target  = ST_DONE;
			end
			ST_RIT: begin
				w.iter_op = IT_CLR;
				w.seq     = SEQ_BRANCH;
				w.target  = ST_DONE;
			end
			ST_GN: begin
				w.seq    = SEQ_BRANCH;
				w.cond   = C_ITER_END;
				w.target = ST_ERR;
			end
			ST_GN_RD: begin
				w.rd   = 1'b1;
				w.addr = A_ITER;
			end
			ST_GN_OUT: begin
				w.load_kd = 1'b1;
				w.iter_op = IT_INC;
				w.seq     = SEQ_BRANCH;
				w.target  = ST_DONE;
			end
			ST_MKE: begin
				w.cnt_op = CNT_CLR;
				w.seq    = SEQ_BRANCH;
				w.target = ST_DONE;
			end
			ST_ERR: begin
				w.set_err = 1'b1;
			end
			ST_DONE: begin
				w.emit   = 1'b1;
				w.seq    = SEQ_WAIT;
				w.cond   = C_OUT_FREE;
				w.target = ST_IDLE;
			end
			default: begin
				w.seq = SEQ_BRANCH;
			end
		endcase
		return w;
	endfunction

	// first step of each request
	function automatic upc_t entry_of(logic [OP_W-1:0] op);
		upc_t s;
		case (op_t'(op))
			OP_INSERT:     s = ST_INS;
			OP_DELETE:     s = ST_DEL_SCAN;
			OP_RETRIEVE:   s = ST_RET_SCAN;
			OP_RESET_ITER: s = ST_RIT;
			OP_GET_NEXT:   s = ST_GN;
			OP_MAKE_EMPTY: s = ST_MKE;
			default:       s = ST_DONE;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/ult_ifs.sv -----
interface ult_req_if;
	logic                         valid;
	logic                         ready;
	logic [ult_pkg::OP_W-1:0]     req_type;
	logic [ult_pkg::KEY_W-1:0]    key_in;
	logic [ult_pkg::DATA_W-1:0]   data_in;

	modport source (output valid, req_type, key_in, data_in, input ready);
	modport sink (input valid, req_type, key_in, data_in, output ready);
endinterface

interface ult_rsp_if #(parameter int CNT_W = 5);
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [ult_pkg::KEY_W-1:0]    key_out;
	logic [ult_pkg::DATA_W-1:0]   data_out;
	logic [CNT_W-1:0]             count;
	logic                         is_full;
	logic                         error;

	modport source (output valid, found, key_out, data_out, count, is_full, error,
		input ready);
	modport sink (input valid, found, key_out, data_out, count, is_full, error,
		output ready);
endinterface

// ----- rtl/ult_ram.sv -----
module ult_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/ult_useq.sv -----
module ult_useq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [ult_pkg::OP_W-1:0] req_type,
	input  ult_pkg::status_t        status,
	output ult_pkg::uword_t         ctrl,
	output logic                    in_ready,
	output logic                    accept
);
	import ult_pkg::*;

	upc_t upc_q;
	upc_t upc_d;
	logic cond_w;

	// fetch the control word
	assign ctrl     = ucode(upc_q);
	assign in_ready = (ctrl.seq == SEQ_DISPATCH);
	assign accept   = in_ready && in_valid;

	// select the jump condition
	always_comb begin
		unique case (ctrl.cond)
			C_TRUE:      cond_w = 1'b1;
			C_FULL:      cond_w = status.full;
			C_MISS:      cond_w = status.miss;
			C_ITER_END:  cond_w = status.iter_end;
			C_SCAN_DONE: cond_w = status.scan_done;
			C_OUT_FREE:  cond_w = status.out_free;
			default:     cond_w = 1'b0;
		endcase
	end

	// advance the step counter
	always_comb begin
		unique case (ctrl.seq)
			SEQ_NEXT:     upc_d = upc_t'(upc_q + 5'd1);
			SEQ_BRANCH:   upc_d = cond_w ? ctrl.target : upc_t'(upc_q + 5'd1);
			SEQ_WAIT:     upc_d = cond_w ? ctrl.target : upc_q;
			SEQ_DISPATCH: upc_d = in_valid ? entry_of(req_type) : upc_q;
			default:      upc_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ----- rtl/ult_dpath.sv -----
module ult_dpath #(
	parameter int CAPACITY = 16,
	parameter int CW       = $clog2(CAPACITY + 1),
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ult_pkg::uword_t           ctrl,
	input  logic                      accept,
	input  logic [ult_pkg::KEY_W-1:0] key_in,
	input  logic [ult_pkg::DATA_W-1:0] data_in,
	input  logic                      out_ready,
	output ult_pkg::status_t          status,
	output logic                      out_valid,
	output logic                      found,
	output logic [ult_pkg::KEY_W-1:0] key_out,
	output logic [ult_pkg::DATA_W-1:0] data_out,
	output logic [CW-1:0]             count,
	output logic                      is_full,
	output logic                      error
);
	import ult_pkg::*;

	localparam int EW = KEY_W + DATA_W;

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     iter_q;
	logic [CW-1:0]     idx_q;
	logic              rd_vld_q;
	logic              found_q;
	logic [AW-1:0]     loc_q;
	logic              err_q;
	logic [KEY_W-1:0]  kout_q;
	logic [DATA_W-1:0] dout_q;

	logic              out_valid_q;
	logic              found_out_q;
	logic [KEY_W-1:0]  key_out_q;
	logic [DATA_W-1:0] data_out_q;
	logic [CW-1:0]     count_out_q;
	logic              full_out_q;
	logic              err_out_q;

	logic [EW-1:0]     rdata;
	logic [EW-1:0]     wdata;
	logic [AW-1:0]     sel_addr;
	logic [AW-1:0]     rd_addr;
	logic [CW-1:0]     last_w;
	logic [CW-1:0]     loc_w;
	logic              hit;
	logic              scan_issue;
	logic              rd_en;
	logic              out_free;
	logic              full_w;

	assign last_w = count_q - CW'(1);
	assign loc_w  = idx_q - CW'(1);
	assign full_w = (count_q == CW'(CAPACITY));

	// pick the table address for single accesses
	always_comb begin
		unique case (ctrl.addr)
			A_COUNT: sel_addr = count_q[AW-1:0];
			A_LAST:  sel_addr = last_w[AW-1:0];
			A_ITER:  sel_addr = iter_q[AW-1:0];
			A_LOC:   sel_addr = loc_q;
			default: sel_addr = '0;
		endcase
	end

	// scan: compare the entry read last cycle, issue the next read
	assign hit        = ctrl.scan && rd_vld_q && (rdata[EW-1:DATA_W] == key_q);
	assign scan_issue = ctrl.scan && !hit && (idx_q < count_q);
	assign rd_en      = scan_issue || ctrl.rd;
	assign rd_addr    = scan_issue ? idx_q[AW-1:0] : sel_addr;
	assign wdata      = ctrl.wd_rdata ? rdata : {key_q, data_q};

	ult_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ctrl.wr),
		.waddr (sel_addr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		status.full      = full_w;
		status.miss      = !found_q;
		status.iter_end  = !(iter_q < count_q);
		status.scan_done = hit || (!rd_vld_q && !(idx_q < count_q));
		status.out_free  = out_free;
	end

	// latch the request payload and the match location
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in;
			data_q <= data_in;
		end
		if (hit) begin
			loc_q <= loc_w[AW-1:0];
		end
	end

	// table and per-request control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			iter_q   <= '0;
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
			err_q    <= 1'b0;
			kout_q   <= '0;
			dout_q   <= '0;
		end else begin
			rd_vld_q <= scan_issue;
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				err_q   <= 1'b0;
				kout_q  <= '0;
				dout_q  <= '0;
			end else begin
				if (scan_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (ctrl.set_err) begin
					err_q <= 1'b1;
				end
				if (ctrl.load_kd) begin
					kout_q <= rdata[EW-1:DATA_W];
					dout_q <= rdata[DATA_W-1:0];
				end
			end
			unique case (ctrl.cnt_op)
				CNT_INC:  count_q <= count_q + CW'(1);
				CNT_DEC:  count_q <= last_w;
				CNT_CLR:  count_q <= '0;
				default:  count_q <= count_q;
			endcase
			unique case (ctrl.iter_op)
				IT_CLR:  iter_q <= '0;
				IT_INC:  iter_q <= iter_q + CW'(1);
				default: iter_q <= iter_q;
			endcase
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			found_out_q <= found_q;
			key_out_q   <= kout_q;
			data_out_q  <= dout_q;
			count_out_q <= count_q;
			full_out_q  <= full_w;
			err_out_q   <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_out_q;
	assign key_out   = key_out_q;
	assign data_out  = data_out_q;
	assign count     = count_out_q;
	assign is_full   = full_out_q;
	assign error     = err_out_q;

endmodule

// ----- rtl/unsorted_list_table.sv -----
// Unsorted key/data table of CAPACITY entries, driven by a small microprogram.
// One request is taken at a time; the next is accepted as soon as the result
// of the previous one sits in the output register, even if not yet taken.
// An unused request code goes straight to the result. Retrieve and delete
// run a linear search, which reads one entry per cycle from the single read
// port of the entry memory (registered read) and compares its key against
// the request key. Entry memory is not cleared after reset; only slots below
// the count are ever read.
module unsorted_list_table #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ult_req_if.sink         req,
	ult_rsp_if.source       rsp
);
	import ult_pkg::*;

	uword_t  ctrl;
	status_t status;
	logic    accept;

	ult_useq u_useq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.req_type (req.req_type),
		.status   (status),
		.ctrl     (ctrl),
		.in_ready (req.ready),
		.accept   (accept)
	);

	ult_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.accept    (accept),
		.key_in    (req.key_in),
		.data_in   (req.data_in),
		.out_ready (rsp.ready),
		.status    (status),
		.out_valid (rsp.valid),
		.found     (rsp.found),
		.key_out   (rsp.key_out),
		.data_out  (rsp.data_out),
		.count     (rsp.count),
		.is_full   (rsp.is_full),
		.error     (rsp.error)
	);

endmodule

// ----- rtl/ult_chk.sv -----
module ult_chk #(
	parameter int CAPACITY = 16,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_found,
	input logic [ult_pkg::KEY_W-1:0]  rsp_key_out,
	input logic [ult_pkg::DATA_W-1:0] rsp_data_out,
	input logic [CW-1:0]              rsp_count,
	input logic                       rsp_is_full,
	input logic                       rsp_error
);

	// count never exceeds the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count <= CW'(CAPACITY)))
		else $error("count above capacity");

	// full flag tracks the count
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_full == (rsp_count == CW'(CAPACITY))))
		else $error("full flag disagrees with count");

	// a failed request carries no match and no entry
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_error) |-> (!rsp_found && rsp_key_out == '0
			&& rsp_data_out == '0))
		else $error("error item carries entry data");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while busy");

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count)
			&& $stable(rsp_key_out) && $stable(rsp_error)))
		else $error("stalled item changed");

endmodule

bind unsorted_list_table ult_chk #(
	.CAPACITY (CAPACITY)
) u_ult_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_found    (rsp.found),
	.rsp_key_out  (rsp.key_out),
	.rsp_data_out (rsp.data_out),
	.rsp_count    (rsp.count),
	.rsp_is_full  (rsp.is_full),
	.rsp_error    (rsp.error)
);
